FILE: hw/rtl/srm_pkg.sv
package srm_pkg;

  localparam int COL_W        = 16;
  localparam int VAL_W        = 32;
  localparam int ENTRY_W      = COL_W + VAL_W;
  localparam int RESULT_LIMIT = 32;
  localparam int RES_W        = $clog2(RESULT_LIMIT + 1);

  // tuser bit positions on the input channel
  localparam int IN_USER_W    = 2;
  localparam int USER_SEL     = 0;
  localparam int USER_NONE    = 1;

  // operand codes
  localparam logic OPERAND_A  = 1'b0;
  localparam logic OPERAND_B  = 1'b1;

  // one stored row entry, column in the low bits
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [COL_W-1:0] column;
  } entry_t;

  // one result handed from the merge engine to the output register
  typedef struct packed {
    logic   valid;
    logic   last;
    logic   empty;
    entry_t entry;
  } result_t;

endpackage

FILE: hw/rtl/srm_row_mem.sv
module srm_row_mem #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  srm_pkg::entry_t       wr_data,
  input  logic [ADDR_W-1:0]     rd_addr,
  output srm_pkg::entry_t       rd_data
);
  import srm_pkg::*;

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/srm_merge.sv
module srm_merge #(
  parameter int MAX_ENTRIES = 16,
  parameter int CNT_W       = 5,
  parameter int IDX_W       = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // load side
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_sel,
  input  logic                  in_none,
  input  logic                  in_last,
  input  logic                  sub_mode,
  // row A memory
  output logic                  a_wr_en,
  output logic [IDX_W-1:0]      a_wr_addr,
  output logic [IDX_W-1:0]      a_rd_addr,
  input  srm_pkg::entry_t       a_rd_data,
  // row B memory
  output logic                  b_wr_en,
  output logic [IDX_W-1:0]      b_wr_addr,
  output logic [IDX_W-1:0]      b_rd_addr,
  input  srm_pkg::entry_t       b_rd_data,
  // result side
  input  logic                  out_free,
  output srm_pkg::result_t      push
);
  import srm_pkg::*;

  typedef enum logic [1:0] {ST_LOAD, ST_READ, ST_CMP, ST_FLUSH} state_t;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);
  localparam logic [RES_W-1:0] RES_MAX = RES_W'(RESULT_LIMIT);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [RES_W-1:0] k_r, k_nxt;
  logic             hold_v_r, hold_v_nxt;
  entry_t           hold_r, hold_nxt;

  logic             accept;
  logic             a_ok, b_ok, take_a, take_b, both;
  logic [VAL_W-1:0] neg_b, comb_val;
  logic             produce;
  entry_t           new_entry;

  assign in_ready = (state_r == ST_LOAD);
  assign accept   = in_valid && in_ready;

  // load writes go to the next free slot; full rows drop entries
  assign a_wr_en   = accept && !in_none && (in_sel == OPERAND_A) && (cnt_a_r < CNT_MAX);
  assign b_wr_en   = accept && !in_none && (in_sel == OPERAND_B) && (cnt_b_r < CNT_MAX);
  assign a_wr_addr = cnt_a_r[IDX_W-1:0];
  assign b_wr_addr = cnt_b_r[IDX_W-1:0];

  // merge pointers address the memories continuously
  assign a_rd_addr = i_r[IDX_W-1:0];
  assign b_rd_addr = j_r[IDX_W-1:0];

  // two-pointer compare on the registered read data
  assign a_ok   = (i_r < cnt_a_r);
  assign b_ok   = (j_r < cnt_b_r);
  assign take_a = !b_ok || (a_ok && (a_rd_data.column < b_rd_data.column));
  assign take_b = !take_a && (!a_ok || (b_rd_data.column < a_rd_data.column));
  assign both   = !take_a && !take_b;

  assign neg_b    = sub_mode ? (VAL_W'(0) - b_rd_data.value) : b_rd_data.value;
  assign comb_val = sub_mode ? (a_rd_data.value - b_rd_data.value)
                             : (a_rd_data.value + b_rd_data.value);

  always_comb begin
    new_entry = a_rd_data;
    produce   = 1'b1;
    if (take_b) begin
      new_entry.column = b_rd_data.column;
      new_entry.value  = neg_b;
    end else if (both) begin
      new_entry.value = comb_val;
      produce         = (comb_val != '0);
    end
  end

  // control: load, read/compare loop, final flush with lookahead hold
  always_comb begin
    state_nxt  = state_r;
    cnt_a_nxt  = cnt_a_r;
    cnt_b_nxt  = cnt_b_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    push       = '0;
    case (state_r)
      ST_LOAD: begin
        if (a_wr_en) cnt_a_nxt = cnt_a_r + CNT_W'(1);
        if (b_wr_en) cnt_b_nxt = cnt_b_r + CNT_W'(1);
        if (accept && (in_sel == OPERAND_B) && in_last) begin
          i_nxt      = '0;
          j_nxt      = '0;
          k_nxt      = '0;
          hold_v_nxt = 1'b0;
          state_nxt  = ST_READ;
        end
      end
      ST_READ: begin
        if ((k_r == RES_MAX) || (!a_ok && !b_ok)) begin
          state_nxt = ST_FLUSH;
        end else begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (!(produce && hold_v_r && !out_free)) begin
          if (produce) begin
            if (hold_v_r) begin
              push.valid = 1'b1;
              push.entry = hold_r;
            end
            hold_v_nxt = 1'b1;
            hold_nxt   = new_entry;
            k_nxt      = k_r + RES_W'(1);
          end
          if (!take_b) i_nxt = i_r + CNT_W'(1);
          if (!take_a) j_nxt = j_r + CNT_W'(1);
          state_nxt = ST_READ;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          push.valid = 1'b1;
          push.last  = 1'b1;
          if (hold_v_r) begin
            push.entry = hold_r;
          end else begin
            push.empty = 1'b1;
          end
          hold_v_nxt = 1'b0;
          cnt_a_nxt  = '0;
          cnt_b_nxt  = '0;
          state_nxt  = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      cnt_a_r  <= '0;
      cnt_b_r  <= '0;
      hold_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_a_r  <= cnt_a_nxt;
      cnt_b_r  <= cnt_b_nxt;
      hold_v_r <= hold_v_nxt;
    end
  end

  // pointers and held result
  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    hold_r <= hold_nxt;
  end

endmodule

FILE: hw/rtl/sparse_row_add_sub_merge.sv
// Channel   Dir  Handshake            Payload
// in_       in   in_tvalid/in_tready  tdata {value, column}, tuser {no_entry, operand_sel},
//                                     tlast last_of_operand
// out_      out  out_tvalid/out_tready tdata {value, column}, tuser row_empty,
//                                     tlast last_result
// cfg_      in   cfg_wr_en            cfg_wr_data subtract_mode
//
// Loading takes one input transaction per cycle into the row memories.
// After the last B item each merge step runs a memory read state, then a
// compare state; a step takes the next A entry, the next B entry, or
// both when their columns meet. A last read state and a flush state end it.
// Input is held off during the merge. The output register stalls the merge
// only when a new result must leave and the register is full.
// Reset (synchronous, rst_n low) clears counts, state, output valid and
// subtract_mode; the row memories need no clearing.
module sparse_row_add_sub_merge #(
  parameter int MAX_ROW_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input entries
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] column, [47:16] value
  input  logic [1:0]  in_tuser,   // [0] operand_sel, [1] no_entry
  input  logic        in_tlast,   // last_of_operand
  // merged results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] out_column, [47:16] out_value
  output logic        out_tuser,  // row_empty
  output logic        out_tlast,  // last_result
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data // subtract_mode
);
  import srm_pkg::*;

  localparam int CNT_W = $clog2(MAX_ROW_ENTRIES + 1);
  localparam int IDX_W = (MAX_ROW_ENTRIES > 1) ? $clog2(MAX_ROW_ENTRIES) : 1;

  logic             sub_mode_r;
  logic             a_wr_en, b_wr_en;
  logic [IDX_W-1:0] a_wr_addr, b_wr_addr, a_rd_addr, b_rd_addr;
  entry_t           a_rd_data, b_rd_data, in_entry;
  result_t          push;
  logic             out_free;
  logic             out_valid_r;
  entry_t           out_entry_r;
  logic             out_empty_r, out_last_r;

  assign in_entry = entry_t'(in_tdata);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      sub_mode_r <= cfg_wr_data;
    end
  end

  srm_row_mem #(.DEPTH(MAX_ROW_ENTRIES), .ADDR_W(IDX_W)) u_row_a (
    .clk     (clk),
    .wr_en   (a_wr_en),
    .wr_addr (a_wr_addr),
    .wr_data (in_entry),
    .rd_addr (a_rd_addr),
    .rd_data (a_rd_data)
  );

  srm_row_mem #(.DEPTH(MAX_ROW_ENTRIES), .ADDR_W(IDX_W)) u_row_b (
    .clk     (clk),
    .wr_en   (b_wr_en),
    .wr_addr (b_wr_addr),
    .wr_data (in_entry),
    .rd_addr (b_rd_addr),
    .rd_data (b_rd_data)
  );

  srm_merge #(.MAX_ENTRIES(MAX_ROW_ENTRIES), .CNT_W(CNT_W), .IDX_W(IDX_W)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sel    (in_tuser[USER_SEL]),
    .in_none   (in_tuser[USER_NONE]),
    .in_last   (in_tlast),
    .sub_mode  (sub_mode_r),
    .a_wr_en   (a_wr_en),
    .a_wr_addr (a_wr_addr),
    .a_rd_addr (a_rd_addr),
    .a_rd_data (a_rd_data),
    .b_wr_en   (b_wr_en),
    .b_wr_addr (b_wr_addr),
    .b_rd_addr (b_rd_addr),
    .b_rd_data (b_rd_data),
    .out_free  (out_free),
    .push      (push)
  );

  // output register
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      out_entry_r <= push.entry;
      out_empty_r <= push.empty;
      out_last_r  <= push.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_entry_r;
  assign out_tuser  = out_empty_r;
  assign out_tlast  = out_last_r;

endmodule
